>>> hdl/phc_pkg.sv
// ----------------------------------------------------------------------------
// phc_pkg
// Shared types and constants for the half-plane polygon clipper.
// ----------------------------------------------------------------------------
package phc_pkg;

  localparam int unsigned CW            = 18;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned DATA_W        = 40;
  localparam int unsigned CFG_IDX_W     = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_X     = 2'd0,
    CFG_NORMAL_Y     = 2'd1,
    CFG_PLANE_OFFSET = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAC,
    ST_OFF,
    ST_EDGE,
    ST_EMIT_S,
    ST_DEN_LD,
    ST_DEN_SUB,
    ST_ABS,
    ST_DIV,
    ST_FIX_LD,
    ST_FIX_ADD,
    ST_EMIT_X,
    ST_FINISH,
    ST_MARK
  } state_e;

endpackage

>>> hdl/polygon_halfplane_clip_top.sv
// ----------------------------------------------------------------------------
// polygon_halfplane_clip_top
// Clips a streamed closed polygon against the half-plane n.P <= offset.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one vertex per word; tlast marks the closing vertex.
//   m_axis carries the clipped vertices; tuser = 1 for a real vertex, 0 for
//   the end-only marker of an empty result; tlast marks the last word of the
//   clipped polygon. cfg_* writes normal_x (0), normal_y (1), plane_offset (2)
//   while the block is idle; the user must keep to this, the block does not enforce it.
//   All arithmetic runs through one shared add/sub unit: signed shift-add
//   multiplies (one multiplier bit per cycle) and restoring division (one
//   quotient bit per cycle). Each edge crossing takes two 36-step products
//   and two 18-step divisions, with up to two crossings on the closing vertex.
//   s_axis_tready_o is high only while the sequencer is idle.
//   A result waits in the output register; while the receiver stalls the
//   sequencer holds before the next emit.
//   Reset clears the configuration registers, the polygon state and the output valid.
// ----------------------------------------------------------------------------
module polygon_halfplane_clip_top #(
  parameter int unsigned FRAC_BITS = phc_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [phc_pkg::CFG_IDX_W-1:0]  cfg_addr_i,
  input  logic [phc_pkg::CW-1:0]         cfg_wdata_i,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // vertex_x [17:0], vertex_y [35:18], zero pad [39:36]
  input  logic [phc_pkg::DATA_W-1:0]     s_axis_tdata_i,
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // out_x [17:0], out_y [35:18], zero pad [39:36]
  output logic [phc_pkg::DATA_W-1:0]     m_axis_tdata_o,
  // has_vertex [0]
  output logic                           m_axis_tuser_o,
  output logic                           m_axis_tlast_o
);

  localparam int unsigned CW  = phc_pkg::CW;
  localparam int unsigned DW  = ((36 > 17 + FRAC_BITS) ? 36 : 17 + FRAC_BITS) + 2;
  localparam int unsigned AW  = DW + CW + 1;
  localparam int unsigned CNW = $clog2(CW);
  localparam logic [CNW-1:0] CNT_END = CNW'(CW - 1);

  // config
  logic [CW-1:0] nx_q, ny_q, off_q;

  // sequencer
  phc_pkg::state_e state_q, state_d;
  logic [CNW-1:0]  cnt_q, cnt_d;
  logic            pass_q, pass_d;
  logic            job_cross_q, job_cross_d;
  logic            axis_q, axis_d;
  logic            edge_q, edge_d;
  logic            have_first_q, have_first_d;
  logic            out_valid_q, out_valid_d;

  // datapath
  logic [AW-1:0]   acc_q, acc_d, mcand_q, mcand_d;
  logic [CW-1:0]   mplr_q, mplr_d, quot_q, quot_d;
  logic            num_neg_q, num_neg_d;
  logic [DW-1:0]   den_q, den_d, dcur_q, dcur_d, dprev_q, dprev_d, dfirst_q, dfirst_d;
  logic [CW-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic            last_q, last_d;
  logic [CW-1:0]   first_x_q, first_x_d, first_y_q, first_y_d;
  logic [CW-1:0]   prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [CW-1:0]   xres_q, xres_d, yres_q, yres_d;
  logic [CW-1:0]   ox_q, ox_d, oy_q, oy_d;
  logic            ohas_q, ohas_d, oend_q, oend_d;

  // shared add/sub unit
  logic            u_lhs_zero, u_rhs_acc, u_sub;
  logic [AW-1:0]   u_lhs, u_rhs, u_res;

  always_comb begin
    u_lhs = u_lhs_zero ? '0 : acc_q;
    u_rhs = u_rhs_acc ? acc_q : mcand_q;
    u_res = u_sub ? (u_lhs - u_rhs) : (u_lhs + u_rhs);
  end

  // edge operands
  logic [CW-1:0] s_x, s_y, e_x, e_y, s_ax, e_ax;
  logic [DW-1:0] ds, de;
  logic          s_in, e_in, crossing;
  logic          cin, pin, fin, a_v, b_v, c_v, d_v;
  logic          end_s, end_x, edge_valid;
  logic [AW-1:0] ds_ext, off_ext;

  always_comb begin
    s_x  = edge_q ? cur_x_q : prev_x_q;
    s_y  = edge_q ? cur_y_q : prev_y_q;
    e_x  = edge_q ? first_x_q : cur_x_q;
    e_y  = edge_q ? first_y_q : cur_y_q;
    ds   = edge_q ? dcur_q : dprev_q;
    de   = edge_q ? dfirst_q : dcur_q;
    s_ax = axis_q ? s_y : s_x;
    e_ax = axis_q ? e_y : e_x;
    s_in = ds[DW-1] | (ds == '0);
    e_in = de[DW-1] | (de == '0);
    crossing = s_in ^ e_in;
    cin  = dcur_q[DW-1] | (dcur_q == '0);
    pin  = dprev_q[DW-1] | (dprev_q == '0);
    fin  = dfirst_q[DW-1] | (dfirst_q == '0);
    a_v  = have_first_q & pin;
    b_v  = have_first_q & (pin ^ cin);
    c_v  = last_q & cin;
    d_v  = last_q & (cin ^ fin);
    end_s = edge_q ? ~d_v : (last_q & ~b_v & ~c_v & ~d_v);
    end_x = edge_q ? 1'b1 : (last_q & ~c_v & ~d_v);
    edge_valid = edge_q ? last_q : have_first_q;
    ds_ext  = {{(AW-DW){ds[DW-1]}}, ds};
    off_ext = {{(AW-CW){off_q[CW-1]}}, off_q} << FRAC_BITS;
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    pass_d       = pass_q;
    job_cross_d  = job_cross_q;
    axis_d       = axis_q;
    edge_d       = edge_q;
    have_first_d = have_first_q;
    out_valid_d  = out_valid_q & ~m_axis_tready_i;
    acc_d        = acc_q;
    mcand_d      = mcand_q;
    mplr_d       = mplr_q;
    quot_d       = quot_q;
    num_neg_d    = num_neg_q;
    den_d        = den_q;
    dcur_d       = dcur_q;
    dprev_d      = dprev_q;
    dfirst_d     = dfirst_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    last_d       = last_q;
    first_x_d    = first_x_q;
    first_y_d    = first_y_q;
    prev_x_d     = prev_x_q;
    prev_y_d     = prev_y_q;
    xres_d       = xres_q;
    yres_d       = yres_q;
    ox_d         = ox_q;
    oy_d         = oy_q;
    ohas_d       = ohas_q;
    oend_d       = oend_q;
    u_lhs_zero   = 1'b0;
    u_rhs_acc    = 1'b0;
    u_sub        = 1'b0;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      phc_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cur_x_d = s_axis_tdata_i[CW-1:0];
          cur_y_d = s_axis_tdata_i[2*CW-1:CW];
          last_d  = s_axis_tlast_i;
          if (!have_first_q) begin
            first_x_d = s_axis_tdata_i[CW-1:0];
            first_y_d = s_axis_tdata_i[2*CW-1:CW];
          end
          acc_d       = '0;
          mcand_d     = {{(AW-CW){nx_q[CW-1]}}, nx_q};
          mplr_d      = s_axis_tdata_i[CW-1:0];
          cnt_d       = '0;
          pass_d      = 1'b0;
          job_cross_d = 1'b0;
          state_d     = phc_pkg::ST_MAC;
        end
      end

      phc_pkg::ST_MAC: begin
        u_sub = (pass_q & job_cross_q) ^ (cnt_q == CNT_END);
        if (mplr_q[0]) begin
          acc_d = u_res;
        end
        mcand_d = mcand_q << 1;
        mplr_d  = mplr_q >> 1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNT_END) begin
          cnt_d = '0;
          if (!pass_q) begin
            pass_d = 1'b1;
            if (job_cross_q) begin
              mcand_d = ds_ext;
              mplr_d  = s_ax;
            end else begin
              mcand_d = {{(AW-CW){ny_q[CW-1]}}, ny_q};
              mplr_d  = cur_y_q;
            end
          end else if (job_cross_q) begin
            state_d = phc_pkg::ST_ABS;
          end else begin
            mcand_d = off_ext;
            state_d = phc_pkg::ST_OFF;
          end
        end
      end

      phc_pkg::ST_OFF: begin
        u_sub  = 1'b1;
        dcur_d = u_res[DW-1:0];
        if (!have_first_q) begin
          dfirst_d = u_res[DW-1:0];
        end
        edge_d  = 1'b0;
        state_d = phc_pkg::ST_EDGE;
      end

      phc_pkg::ST_EDGE: begin
        axis_d = 1'b0;
        if (edge_valid && s_in) begin
          state_d = phc_pkg::ST_EMIT_S;
        end else if (edge_valid && crossing) begin
          state_d = phc_pkg::ST_DEN_LD;
        end else if (!edge_q) begin
          edge_d = 1'b1;
        end else begin
          state_d = phc_pkg::ST_FINISH;
        end
      end

      phc_pkg::ST_EMIT_S: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          ox_d   = s_x;
          oy_d   = s_y;
          ohas_d = 1'b1;
          oend_d = end_s;
          if (crossing) begin
            state_d = phc_pkg::ST_DEN_LD;
          end else if (!edge_q) begin
            edge_d  = 1'b1;
            state_d = phc_pkg::ST_EDGE;
          end else begin
            state_d = phc_pkg::ST_FINISH;
          end
        end
      end

      phc_pkg::ST_DEN_LD: begin
        // |ds - de|: larger side minus smaller side
        if (s_in) begin
          acc_d   = {{(AW-DW){de[DW-1]}}, de};
          mcand_d = ds_ext;
        end else begin
          acc_d   = ds_ext;
          mcand_d = {{(AW-DW){de[DW-1]}}, de};
        end
        state_d = phc_pkg::ST_DEN_SUB;
      end

      phc_pkg::ST_DEN_SUB: begin
        u_sub       = 1'b1;
        den_d       = u_res[DW-1:0];
        acc_d       = '0;
        mcand_d     = ds_ext;
        mplr_d      = e_ax;
        cnt_d       = '0;
        pass_d      = 1'b0;
        job_cross_d = 1'b1;
        state_d     = phc_pkg::ST_MAC;
      end

      phc_pkg::ST_ABS: begin
        num_neg_d  = acc_q[AW-1];
        u_lhs_zero = 1'b1;
        u_rhs_acc  = 1'b1;
        u_sub      = 1'b1;
        if (acc_q[AW-1]) begin
          acc_d = u_res;
        end
        mcand_d = {{(AW-DW){1'b0}}, den_q} << (CW - 1);
        quot_d  = '0;
        cnt_d   = '0;
        state_d = phc_pkg::ST_DIV;
      end

      phc_pkg::ST_DIV: begin
        u_sub = 1'b1;
        if (!u_res[AW-1]) begin
          acc_d = u_res;
        end
        quot_d  = {quot_q[CW-2:0], ~u_res[AW-1]};
        mcand_d = mcand_q >> 1;
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CNT_END) begin
          state_d = phc_pkg::ST_FIX_LD;
        end
      end

      phc_pkg::ST_FIX_LD: begin
        acc_d   = {{(AW-CW){s_ax[CW-1]}}, s_ax};
        mcand_d = {{(AW-CW){1'b0}}, quot_q};
        state_d = phc_pkg::ST_FIX_ADD;
      end

      phc_pkg::ST_FIX_ADD: begin
        // quotient sign: numerator sign xor denominator sign (negative when S inside)
        u_sub = num_neg_q ^ s_in;
        if (!axis_q) begin
          xres_d      = u_res[CW-1:0];
          axis_d      = 1'b1;
          acc_d       = '0;
          mcand_d     = ds_ext;
          mplr_d      = e_y;
          cnt_d       = '0;
          pass_d      = 1'b0;
          state_d     = phc_pkg::ST_MAC;
        end else begin
          yres_d  = u_res[CW-1:0];
          state_d = phc_pkg::ST_EMIT_X;
        end
      end

      phc_pkg::ST_EMIT_X: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          ox_d   = xres_q;
          oy_d   = yres_q;
          ohas_d = 1'b1;
          oend_d = end_x;
          axis_d = 1'b0;
          if (!edge_q) begin
            edge_d  = 1'b1;
            state_d = phc_pkg::ST_EDGE;
          end else begin
            state_d = phc_pkg::ST_FINISH;
          end
        end
      end

      phc_pkg::ST_FINISH: begin
        prev_x_d     = cur_x_q;
        prev_y_d     = cur_y_q;
        dprev_d      = dcur_q;
        have_first_d = ~last_q;
        if (last_q && !(a_v || b_v || c_v || d_v)) begin
          state_d = phc_pkg::ST_MARK;
        end else begin
          state_d = phc_pkg::ST_IDLE;
        end
      end

      phc_pkg::ST_MARK: begin
        if (!out_valid_q) begin
          out_valid_d = 1'b1;
          ox_d    = '0;
          oy_d    = '0;
          ohas_d  = 1'b0;
          oend_d  = 1'b1;
          state_d = phc_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = phc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= phc_pkg::ST_IDLE;
      have_first_q <= 1'b0;
      out_valid_q  <= 1'b0;
      first_x_q    <= '0;
      first_y_q    <= '0;
      prev_x_q     <= '0;
      prev_y_q     <= '0;
      nx_q         <= '0;
      ny_q         <= '0;
      off_q        <= '0;
    end else begin
      state_q      <= state_d;
      have_first_q <= have_first_d;
      out_valid_q  <= out_valid_d;
      first_x_q    <= first_x_d;
      first_y_q    <= first_y_d;
      prev_x_q     <= prev_x_d;
      prev_y_q     <= prev_y_d;
      if (cfg_we_i) begin
        unique case (phc_pkg::cfg_idx_e'(cfg_addr_i))
          phc_pkg::CFG_NORMAL_X:     nx_q  <= cfg_wdata_i;
          phc_pkg::CFG_NORMAL_Y:     ny_q  <= cfg_wdata_i;
          phc_pkg::CFG_PLANE_OFFSET: off_q <= cfg_wdata_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    pass_q      <= pass_d;
    job_cross_q <= job_cross_d;
    axis_q      <= axis_d;
    edge_q      <= edge_d;
    acc_q       <= acc_d;
    mcand_q     <= mcand_d;
    mplr_q      <= mplr_d;
    quot_q      <= quot_d;
    num_neg_q   <= num_neg_d;
    den_q       <= den_d;
    dcur_q      <= dcur_d;
    dprev_q     <= dprev_d;
    dfirst_q    <= dfirst_d;
    cur_x_q     <= cur_x_d;
    cur_y_q     <= cur_y_d;
    last_q      <= last_d;
    xres_q      <= xres_d;
    yres_q      <= yres_d;
    ox_q        <= ox_d;
    oy_q        <= oy_d;
    ohas_q      <= ohas_d;
    oend_q      <= oend_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(phc_pkg::DATA_W-2*CW){1'b0}}, oy_q, ox_q};
  assign m_axis_tuser_o  = ohas_q;
  assign m_axis_tlast_o  = oend_q;

endmodule

>>> test/tb.sv
// ----------------------------------------------------------------------------
// tb
// Streams closed polygons into polygon_halfplane_clip_top and checks every
// clipped word against a behavioral clipper running inside the bench, or
// against the expected word of a typed table row. A short table of directed
// rows comes first: coordinate extremes, empty clips, crossings and register
// extremes. Random polygons under random planes follow. Both stream sides
// draw random gaps, and the output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CW          = phc_pkg::CW;
  localparam int unsigned DATA_W      = phc_pkg::DATA_W;
  localparam int unsigned CFG_IDX_W   = phc_pkg::CFG_IDX_W;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned SETTLE      = 300;
  localparam int unsigned RAND_VERTS  = 195;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int          CMIN        = -131072;
  localparam int          CMAX        = 131071;
  localparam longint      OFF_SCALE   = longint'(1) << phc_pkg::FRAC_BITS_DEF;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          has;
    logic          eop;
  } clip_word_t;

  typedef enum logic {ROW_VTX, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e  kind;
    int         a;
    int         b;
    int         c;
    bit         typed;
    int         n_want;
    clip_word_t want;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_addr;
  logic [CW-1:0]        cfg_wdata;
  logic                 s_valid;
  logic                 s_ready;
  logic [DATA_W-1:0]    s_data;
  logic                 s_last;
  logic                 m_valid;
  logic                 m_rdy;
  logic [DATA_W-1:0]    m_data;
  logic                 m_user;
  logic                 m_last;

  polygon_halfplane_clip_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_addr_i      (cfg_addr),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_rdy),
    .m_axis_tdata_o  (m_data),
    .m_axis_tuser_o  (m_user),
    .m_axis_tlast_o  (m_last)
  );

  // clipper state
  longint nrm_x = 0;
  longint nrm_y = 0;
  longint plane_off = 0;
  longint first_x = 0;
  longint first_y = 0;
  longint prev_x = 0;
  longint prev_y = 0;
  bit     have_first = 1'b0;

  clip_word_t  clip_q[$];
  clip_word_t  item_q[$];
  int unsigned n_sent = 0;
  int unsigned n_got = 0;
  int unsigned n_fail = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic clip_word_t mk_word(longint x, longint y, logic has, logic eop);
    clip_word_t w;
    w.x   = x[CW-1:0];
    w.y   = y[CW-1:0];
    w.has = has;
    w.eop = eop;
    return w;
  endfunction

  function automatic longint plane_dist(longint x, longint y);
    return x * nrm_x + y * nrm_y - plane_off * OFF_SCALE;
  endfunction

  function automatic void edge_words(longint sx, longint sy, longint ex, longint ey);
    longint ds;
    longint de;
    longint den;
    ds  = plane_dist(sx, sy);
    de  = plane_dist(ex, ey);
    den = ds - de;
    if (ds <= 0) item_q.push_back(mk_word(sx, sy, 1'b1, 1'b0));
    if ((ds <= 0) != (de <= 0))
      item_q.push_back(mk_word(sx + (ex - sx) * ds / den, sy + (ey - sy) * ds / den,
                               1'b1, 1'b0));
  endfunction

  function automatic void clip_vertex(longint x, longint y, bit last);
    item_q.delete();
    if (!have_first) begin
      first_x    = x;
      first_y    = y;
      have_first = 1'b1;
    end else begin
      edge_words(prev_x, prev_y, x, y);
    end
    prev_x = x;
    prev_y = y;
    if (last) begin
      edge_words(x, y, first_x, first_y);
      if (item_q.size() == 0) item_q.push_back(mk_word(0, 0, 1'b0, 1'b0));
      item_q[item_q.size()-1].eop = 1'b1;
      have_first = 1'b0;
    end
  endfunction

  function automatic void check_field(string name, logic [CW-1:0] want, logic [CW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, $signed(want), $signed(got));
      n_fail++;
    end
  endfunction

  task automatic take_word();
    clip_word_t got;
    clip_word_t want;
    got.x   = m_data[CW-1:0];
    got.y   = m_data[2*CW-1:CW];
    got.has = m_user;
    got.eop = m_last;
    n_got++;
    if (clip_q.size() == 0) begin
      $display("%0t: unexpected word x=%0d y=%0d has=%0b eop=%0b", $time,
               $signed(got.x), $signed(got.y), got.has, got.eop);
      n_fail++;
    end else begin
      want = clip_q.pop_front();
      check_field("out_x", want.x, got.x);
      check_field("out_y", want.y, got.y);
      check_field("has_vertex", CW'(want.has), CW'(got.has));
      check_field("end_of_polygon", CW'(want.eop), CW'(got.eop));
    end
  endtask

  function automatic int unsigned tx_gap();
    return ((n_sent % 48) < 12) ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic int unsigned rx_gap();
    return ((n_got % 40) < 10) ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic int rand_reg();
    case ($urandom_range(0, 7))
      0: return CMIN;
      1: return CMAX;
      2: return 0;
      default: return int'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(0, 9))
      0: return CMIN;
      1: return CMAX;
      2, 3: return int'($urandom_range(0, 2047)) - 1024;
      default: return int'($urandom_range(0, 262143)) - 131072;
    endcase
  endfunction

  function automatic int unsigned poly_sides();
    case ($urandom_range(0, 9))
      0: return 1;
      1: return 2;
      default: return $urandom_range(3, 8);
    endcase
  endfunction

  task automatic send_vertex(int x, int y, bit last, bit typed, int n_want,
                             clip_word_t want);
    int unsigned gap;
    gap = tx_gap();
    if (gap != 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(DATA_W-2*CW){1'b0}}, y[CW-1:0], x[CW-1:0]};
    s_last  <= last;
    do @(posedge clk_i); while (!s_ready);
    clip_vertex(x, y, last);
    if (typed) begin
      if (n_want != 0) clip_q.push_back(want);
    end else begin
      foreach (item_q[i]) clip_q.push_back(item_q[i]);
    end
    n_sent++;
  endtask

  task automatic drain();
    s_valid <= 1'b0;
    while (clip_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_plane(int nx, int ny, int off);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= phc_pkg::CFG_NORMAL_X;
    cfg_wdata <= nx[CW-1:0];
    @(posedge clk_i);
    cfg_addr  <= phc_pkg::CFG_NORMAL_Y;
    cfg_wdata <= ny[CW-1:0];
    @(posedge clk_i);
    cfg_addr  <= phc_pkg::CFG_PLANE_OFFSET;
    cfg_wdata <= off[CW-1:0];
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    nrm_x     = nx;
    nrm_y     = ny;
    plane_off = off;
  endtask

  function automatic stim_row_t vrow(int x, int y, bit last);
    return '{ROW_VTX, x, y, int'(last), 1'b0, 0, '0};
  endfunction

  function automatic stim_row_t trow(int x, int y, bit last, int n, int wx, int wy,
                                     bit whas);
    return '{ROW_VTX, x, y, int'(last), 1'b1, n, mk_word(wx, wy, whas, 1'b1)};
  endfunction

  function automatic stim_row_t crow(int nx, int ny, int off);
    return '{ROW_CFG, nx, ny, off, 1'b0, 0, '0};
  endfunction

  // output side: random gaps, one long hold-off
  initial begin : word_sink
    int unsigned gap;
    m_rdy <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (!m_rdy) begin
        m_rdy <= 1'b1;
      end else if (m_valid) begin
        take_word();
        gap = (n_got == 50) ? LONG_HOLD : rx_gap();
        if (gap != 0) begin
          m_rdy <= 1'b0;
          repeat (gap) @(posedge clk_i);
          m_rdy <= 1'b1;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_rdy && m_valid) || cfg_we) quiet = 0;
      else quiet++;
    end
    $display("polygon_halfplane_clip_top test failed");
    $finish;
  end

  initial begin : stimulus
    stim_row_t   dir_rows [30];
    int unsigned nv;
    int unsigned next_cfg;
    int unsigned sides;

    rst_ni    <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= phc_pkg::CFG_NORMAL_X;
    cfg_wdata <= '0;
    s_valid   <= 1'b0;
    s_data    <= '0;
    s_last    <= 1'b0;

    dir_rows = '{
      // zero plane after reset: everything inside
      trow(CMIN, CMIN, 1, 1, CMIN, CMIN, 1),
      trow(CMAX, CMAX, 1, 1, CMAX, CMAX, 1),
      trow(0, 0, 1, 1, 0, 0, 1),
      trow(100, -5, 0, 0, 0, 0, 0),
      vrow(-7, 3, 0),
      vrow(9, 9, 1),
      // everything outside: empty clip markers
      crow(0, 0, -1),
      trow(5, 5, 1, 1, 0, 0, 0),
      trow(CMAX, CMIN, 0, 0, 0, 0, 0),
      trow(CMIN, CMAX, 0, 0, 0, 0, 0),
      trow(0, 0, 1, 1, 0, 0, 0),
      // x <= 0 through a square
      crow(65536, 0, 0),
      vrow(-65536, -65536, 0),
      vrow(65536, -65536, 0),
      vrow(65536, 65536, 0),
      vrow(-65536, 65536, 1),
      // closing vertex crosses twice
      vrow(-65536, 0, 0),
      vrow(-32768, 65536, 0),
      vrow(98304, 0, 1),
      // register extremes
      crow(CMIN, CMAX, CMAX),
      vrow(CMAX, CMIN, 0),
      vrow(CMIN, CMAX, 0),
      vrow(0, 0, 1),
      crow(CMAX, CMIN, CMIN),
      vrow(CMAX, CMAX, 0),
      vrow(CMIN, CMIN, 0),
      vrow(65536, -65536, 1),
      // zero normal, all inside
      crow(0, 0, CMAX),
      vrow(-1, 1, 0),
      vrow(1, -1, 1)
    };

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        set_plane(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c);
      else
        send_vertex(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c[0], dir_rows[i].typed,
                    dir_rows[i].n_want, dir_rows[i].want);
    end

    nv       = 0;
    next_cfg = 0;
    while (nv < RAND_VERTS) begin
      if (nv >= next_cfg) begin
        set_plane(rand_reg(), rand_reg(), rand_reg());
        next_cfg = nv + 30 + $urandom_range(0, 20);
      end
      sides = poly_sides();
      for (int unsigned k = 0; k < sides; k++)
        send_vertex(rand_coord(), rand_coord(), k == sides - 1, 1'b0, 0, '0);
      nv += sides;
    end

    drain();
    if (n_fail == 0) begin
      $display("polygon_halfplane_clip_top test passed");
    end else begin
      $display("polygon_halfplane_clip_top test failed");
    end
    $finish;
  end

endmodule
